>>> sv/djq_pkg.sv
// package for the deadline expiring job queue
// shared widths, action codes and the cell control struct; no dependencies
package djq_pkg;
    localparam int QueueDepth = 16;
    localparam int TimeBits = 48;
    localparam int TagBits = 16;
    localparam int FillBits = $clog2(QueueDepth + 1);
    localparam int IdxBits = $clog2(QueueDepth);

    typedef enum logic [2:0] {
        ACT_SENT    = 3'd0,
        ACT_EXPIRED = 3'd1,
        ACT_DROPPED = 3'd2,
        ACT_QUEUED  = 3'd3,
        ACT_EMPTY   = 3'd4
    } action_t;

    typedef struct packed {
        logic [TagBits-1:0]  tag;
        logic [TimeBits-1:0] deadline;
        logic [TimeBits-1:0] arrival;
    } entry_t;

    // control broadcast to every cell
    typedef struct packed {
        logic shift;    // every cell takes its right neighbor
        logic load;     // tail cell takes the new entry
        logic [IdxBits-1:0] load_idx;
    } cell_ctrl_t;
endpackage

>>> sv/deadline_expiring_job_queue_unit.sv
// A request or a dropped arrival is answered from the idle state. An accepted arrival
// passes through the accepting step, one scan step per queued entry, since the expiry
// scan rotates the chain of cells one place a step and tests the head cell only, a step
// to leave the scan and a step for the final result.
// Results leave through a one-item output register, and a stalled output holds the scan.
// depends on djq_pkg and djq_cell
module deadline_expiring_job_queue_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // job_tag, now_time, deadline, server_busy,
                                        // server_on_vacation, zero fill
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // out_tag, waited_time, queue_fill, zero fill
    output logic [2:0]   m_axis_tuser,  // action
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int D = djq_pkg::QueueDepth;
    localparam int FB = djq_pkg::FillBits;
    localparam int IB = djq_pkg::IdxBits;
    localparam int TB = djq_pkg::TimeBits;
    localparam int GB = djq_pkg::TagBits;
    localparam logic [1:0] AddrCap = 2'd0;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINAL} state_t;

    state_t state_reg;
    logic [4:0] cap_reg;
    logic [FB-1:0] fill_reg, fill_next;
    logic [FB-1:0] scan_reg;   // entries left to test
    logic [FB-1:0] keep_reg;   // entries kept so far
    logic [GB-1:0] tag_reg;
    logic [TB-1:0] now_reg, dl_reg;
    logic          queue_reg;  // new job goes to the queue
    logic          ovalid_reg, olast_reg;
    djq_pkg::action_t oact_reg;
    logic [GB-1:0] otag_reg;
    logic [TB-1:0] owait_reg;
    logic [FB-1:0] ofill_reg;

    djq_pkg::entry_t cells [D];
    djq_pkg::entry_t rights [D];
    djq_pkg::entry_t new_entry, head_entry, rot_entry;
    djq_pkg::cell_ctrl_t ctrl;
    logic rotate;

    wire in_fire  = s_axis_tvalid && s_axis_tready;
    wire out_free = !ovalid_reg || m_axis_tready;
    wire [GB-1:0] in_tag = s_axis_tdata[GB-1:0];
    wire [TB-1:0] in_now = s_axis_tdata[GB +: TB];
    wire [TB-1:0] in_dl  = s_axis_tdata[GB+TB +: TB];
    wire in_busy = s_axis_tdata[GB+2*TB];
    wire in_vac  = s_axis_tdata[GB+2*TB+1];
    wire [FB-1:0] cap_eff = (FB'(cap_reg) > FB'(D)) ? FB'(D) : FB'(cap_reg);
    assign head_entry = cells[0];
    wire head_exp = head_entry.deadline < now_reg;
    // a result enters the output register this cycle
    wire out_load = (state_reg == ST_IDLE && in_fire && (s_axis_tuser || fill_reg >= cap_eff))
        || (state_reg == ST_SCAN && out_free && scan_reg != '0 && head_exp)
        || (state_reg == ST_FINAL && out_free);

    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign pready = 1'b1;
    assign prdata = (paddr == AddrCap) ? {27'd0, cap_reg} : 32'd0;

    // scan rotates a kept head to the back of the live region
    assign rotate = (state_reg == ST_SCAN) && out_free && (scan_reg != '0) && !head_exp;
    assign rot_entry = head_entry;
    always_comb
    begin
        ctrl.shift = 1'b0;
        ctrl.load = 1'b0;
        ctrl.load_idx = '0;
        new_entry = '{tag: tag_reg, deadline: dl_reg, arrival: now_reg};
        if (in_fire && s_axis_tuser && fill_reg != '0)
        begin
            ctrl.shift = 1'b1;
        end
        else if (state_reg == ST_SCAN && out_free && scan_reg != '0)
        begin
            ctrl.shift = 1'b1;
            if (rotate)
            begin
                ctrl.load = 1'b1;
                ctrl.load_idx = IB'(fill_reg - 1'b1);
                new_entry = rot_entry;
            end
        end
        else if (state_reg == ST_FINAL && out_free && queue_reg && fill_reg != FB'(D))
        begin
            ctrl.load = 1'b1;
            ctrl.load_idx = IB'(fill_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            if (g == D - 1)
            begin : g_end
                assign rights[g] = cells[g];
            end
            else
            begin : g_mid
                assign rights[g] = cells[g+1];
            end
            djq_cell u_cell (
                .clk(clk), .ctrl(ctrl), .idx(IB'(g)), .right(rights[g]),
                .new_entry(new_entry), .entry(cells[g])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (state_reg == ST_SCAN && out_free && scan_reg != '0 && head_exp)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg <= 5'd16;
            fill_reg <= '0;
            scan_reg <= '0;
            keep_reg <= '0;
            tag_reg <= '0;
            now_reg <= '0;
            dl_reg <= '0;
            queue_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            olast_reg <= 1'b0;
            oact_reg <= djq_pkg::ACT_EMPTY;
            otag_reg <= '0;
            owait_reg <= '0;
            ofill_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == AddrCap)
            begin
                cap_reg <= pwdata[4:0];
            end
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        tag_reg <= in_tag;
                        now_reg <= in_now;
                        dl_reg <= in_dl;
                        queue_reg <= in_busy || in_vac;
                        if (s_axis_tuser)
                        begin
                            olast_reg <= 1'b1;
                            if (fill_reg == '0)
                            begin
                                oact_reg <= djq_pkg::ACT_EMPTY;
                                otag_reg <= '0;
                                owait_reg <= '0;
                                ofill_reg <= '0;
                            end
                            else
                            begin
                                oact_reg <= djq_pkg::ACT_SENT;
                                otag_reg <= head_entry.tag;
                                owait_reg <= in_now - head_entry.arrival;
                                fill_reg <= fill_reg - 1'b1;
                                ofill_reg <= fill_reg - 1'b1;
                            end
                        end
                        else if (fill_reg >= cap_eff)
                        begin
                            olast_reg <= 1'b1;
                            oact_reg <= djq_pkg::ACT_DROPPED;
                            otag_reg <= in_tag;
                            owait_reg <= '0;
                            ofill_reg <= fill_reg;
                        end
                        else
                        begin
                            scan_reg <= fill_reg;
                            keep_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_reg == '0)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else if (out_free)
                    begin
                        scan_reg <= scan_reg - 1'b1;
                        fill_reg <= fill_next;
                        if (head_exp)
                        begin
                            olast_reg <= 1'b0;
                            oact_reg <= djq_pkg::ACT_EXPIRED;
                            otag_reg <= head_entry.tag;
                            owait_reg <= '0;
                            ofill_reg <= fill_next;
                        end
                        else
                        begin
                            keep_reg <= keep_reg + 1'b1;
                        end
                    end
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        olast_reg <= 1'b1;
                        otag_reg <= tag_reg;
                        owait_reg <= '0;
                        state_reg <= ST_IDLE;
                        if (queue_reg)
                        begin
                            oact_reg <= djq_pkg::ACT_QUEUED;
                            if (fill_reg != FB'(D))
                            begin
                                fill_reg <= fill_reg + 1'b1;
                                ofill_reg <= fill_reg + 1'b1;
                            end
                            else
                            begin
                                ofill_reg <= fill_reg;
                            end
                        end
                        else
                        begin
                            oact_reg <= djq_pkg::ACT_SENT;
                            ofill_reg <= fill_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast = olast_reg;
    assign m_axis_tuser = oact_reg;
    assign m_axis_tdata = {3'd0, ofill_reg, owait_reg, otag_reg};

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FB'(D)) else $error("fill above depth");
    a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> keep_reg + scan_reg <= fill_reg)
        else $error("scan counters out of step");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready) else $error("accept during scan");
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == ST_FINAL && out_free) |-> ovalid_reg && olast_reg)
        else $error("final result missing last");
`endif
endmodule

>>> sv/djq_cell.sv
// one queue cell: holds an entry, takes the new entry when addressed, else shifts toward the head
// depends on djq_pkg
module djq_cell (
    input  logic                 clk,
    input  djq_pkg::cell_ctrl_t  ctrl,
    input  logic [djq_pkg::IdxBits-1:0] idx,
    input  djq_pkg::entry_t      right,
    input  djq_pkg::entry_t      new_entry,
    output djq_pkg::entry_t      entry
);
    djq_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && ctrl.load_idx == idx)
        begin
            entry_reg <= new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= right;
        end
    end

    assign entry = entry_reg;
endmodule

>>> bench/deadline_expiring_job_queue_unit_tb.sv
// testbench for deadline_expiring_job_queue_unit: drives arrivals and requests over
// the stream port, writes the capacity over apb, predicts each result in a queue model
// depends on djq_pkg and the rtl of the block
`timescale 1ns / 1ps

module deadline_expiring_job_queue_unit_tb;
    localparam logic [1:0] CapAddr = 2'd0;
    localparam int IdleLimit = 5000;

    typedef struct packed {
        logic [djq_pkg::TagBits-1:0]  tag;
        logic [djq_pkg::TimeBits-1:0] waited;
        logic [djq_pkg::FillBits-1:0] fill;
        djq_pkg::action_t             act;
        logic                         last;
    } job_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    deadline_expiring_job_queue_unit u_top (.*);

    always #5 clk = ~clk;

    // model of the queue
    djq_pkg::entry_t queued_jobs[$];
    int          capacity = djq_pkg::QueueDepth;
    job_result_t pending_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          expired_seen = 0;
    int          dropped_seen = 0;
    bit          hold_stall = 1'b0;

    task automatic predict_job(input logic func, input logic [djq_pkg::TagBits-1:0] tag,
                               input logic [djq_pkg::TimeBits-1:0] now,
                               input logic [djq_pkg::TimeBits-1:0] dl,
                               input logic busy, input logic vac);
        job_result_t r;
        djq_pkg::entry_t e;
        djq_pkg::entry_t kept[$];
        int cap;
        cap = capacity > djq_pkg::QueueDepth ? djq_pkg::QueueDepth : capacity;
        r = '0;
        if (func)
        begin
            r.last = 1'b1;
            if (queued_jobs.size() == 0)
                r.act = djq_pkg::ACT_EMPTY;
            else
            begin
                e = queued_jobs.pop_front();
                r.act = djq_pkg::ACT_SENT;
                r.tag = e.tag;
                r.waited = now - e.arrival;
                r.fill = djq_pkg::FillBits'(queued_jobs.size());
            end
            pending_results.push_back(r);
            return;
        end
        if (queued_jobs.size() >= cap)
        begin
            r.act = djq_pkg::ACT_DROPPED;
            r.tag = tag;
            r.fill = djq_pkg::FillBits'(queued_jobs.size());
            r.last = 1'b1;
            pending_results.push_back(r);
            return;
        end
        // expiry scan: fill counts down as entries are removed
        r.fill = djq_pkg::FillBits'(queued_jobs.size());
        foreach (queued_jobs[i])
        begin
            if (queued_jobs[i].deadline < now)
            begin
                r.fill = r.fill - 1'b1;
                r.act = djq_pkg::ACT_EXPIRED;
                r.tag = queued_jobs[i].tag;
                pending_results.push_back(r);
            end
            else
                kept.push_back(queued_jobs[i]);
        end
        queued_jobs = kept;
        r.tag = tag;
        r.last = 1'b1;
        if (!busy && !vac)
            r.act = djq_pkg::ACT_SENT;
        else
        begin
            e.tag = tag;
            e.deadline = dl;
            e.arrival = now;
            queued_jobs.push_back(e);
            r.act = djq_pkg::ACT_QUEUED;
        end
        r.fill = djq_pkg::FillBits'(queued_jobs.size());
        pending_results.push_back(r);
    endtask

    // sends one item, sometimes after a random gap
    task automatic send_job(input logic func, input logic [djq_pkg::TagBits-1:0] tag,
                            input logic [djq_pkg::TimeBits-1:0] now,
                            input logic [djq_pkg::TimeBits-1:0] dl,
                            input logic busy, input logic vac);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        s_axis_tuser <= func;
        s_axis_tdata <= {5'b0, vac, busy, dl, now, tag};
        s_axis_tvalid <= 1'b1;
        predict_job(func, tag, now, dl, busy, vac);
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (djq_pkg::QueueDepth + 4)
            @(negedge clk);
    endtask

    task automatic write_capacity(input int value);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= CapAddr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity = value & 32'h1f;
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if ($urandom_range(0, 15) == 0)
            hold_stall <= ~hold_stall;
        m_axis_tready <= hold_stall ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        job_result_t got;
        job_result_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("%0t watchdog: no progress", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.tag = m_axis_tdata[15:0];
            got.waited = m_axis_tdata[63:16];
            got.fill = m_axis_tdata[68:64];
            got.act = djq_pkg::action_t'(m_axis_tuser);
            got.last = m_axis_tlast;
            results_seen++;
            if (got.act == djq_pkg::ACT_EXPIRED)
                expired_seen++;
            if (got.act == djq_pkg::ACT_DROPPED)
                dropped_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: %p", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.act != want.act)
                    $display("%0t action exp %0d got %0d", $time, want.act, got.act);
                if (got.tag != want.tag)
                    $display("%0t tag exp %h got %h", $time, want.tag, got.tag);
                if (got.waited != want.waited)
                    $display("%0t waited exp %h got %h", $time, want.waited, got.waited);
                if (got.fill != want.fill)
                    $display("%0t fill exp %0d got %0d", $time, want.fill, got.fill);
                if (got.last != want.last)
                    $display("%0t last exp %b got %b", $time, want.last, got.last);
                if (got != want)
                    errors++;
            end
        end
    end

    task automatic test_directed();
        send_job(1'b1, 16'hffff, '1, '1, 1'b1, 1'b1);
        send_job(1'b0, 16'h0000, 48'd0, 48'd0, 1'b0, 1'b0);
        send_job(1'b0, 16'hffff, 48'd10, '1, 1'b1, 1'b0);
        send_job(1'b0, 16'h0001, 48'd10, 48'd5, 1'b0, 1'b1);
        send_job(1'b0, 16'h0002, 48'd10, 48'd10, 1'b1, 1'b1);
        send_job(1'b1, 16'h0000, 48'd3, 48'd0, 1'b0, 1'b0);
        send_job(1'b0, 16'h0003, 48'd11, 48'd11, 1'b0, 1'b0);
        send_job(1'b0, 16'h0004, '1, 48'd20, 1'b1, 1'b1);
        send_job(1'b1, 16'h0000, '1, 48'd0, 1'b0, 1'b0);
        send_job(1'b1, 16'h0000, 48'd0, 48'd0, 1'b0, 1'b0);
        send_job(1'b1, 16'h0000, 48'd0, 48'd0, 1'b0, 1'b0);
        for (int i = 0; i < 17; i++)
            send_job(1'b0, djq_pkg::TagBits'(16'h0100 + i), 48'd100, 48'd200, 1'b1, 1'b0);
    endtask

    task automatic test_capacity();
        write_capacity(0);
        send_job(1'b0, 16'h0aaa, 48'd300, 48'd400, 1'b1, 1'b1);
        write_capacity(31);
        // the queue is still full, so this arrival is dropped even at capacity 31
        send_job(1'b0, 16'h0bbb, 48'd500, 48'd600, 1'b1, 1'b1);
        write_capacity(3);
        for (int i = 0; i < 5; i++)
            send_job(1'b0, djq_pkg::TagBits'(16'h0c00 + i), 48'd500, 48'd900, 1'b1, 1'b0);
    endtask

    task automatic random_phase(input int count, input int cap);
        logic [djq_pkg::TimeBits-1:0] clock_now;
        logic [djq_pkg::TimeBits-1:0] dl;
        logic noise;
        write_capacity(cap);
        clock_now = djq_pkg::TimeBits'({$urandom, $urandom});
        for (int i = 0; i < count; i++)
        begin
            noise = ($urandom_range(0, 9) == 0);
            if (noise)
                clock_now = djq_pkg::TimeBits'({$urandom, $urandom});
            else
                clock_now = clock_now + $urandom_range(0, 20);
            dl = noise ? djq_pkg::TimeBits'({$urandom, $urandom})
                       : clock_now + $urandom_range(0, 60);
            send_job($urandom_range(0, 2) == 0, djq_pkg::TagBits'($urandom), clock_now, dl,
                     $urandom_range(0, 4) != 0, $urandom_range(0, 1) != 0);
        end
    endtask

    initial
    begin
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_capacity();
        random_phase(110, 16);
        random_phase(90, 4);
        random_phase(80, 1);
        random_phase(60, 20);
        wait_drained();
        $display("covered %0d items, %0d results (%0d expired, %0d dropped)",
                 items_sent, results_seen, expired_seen, dropped_seen);
        $display("capacity settings 0, 1, 3, 4, 16, 20 and 31 with random stalls");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> files.f
sv/djq_pkg.sv
sv/djq_cell.sv
sv/deadline_expiring_job_queue_unit.sv
bench/deadline_expiring_job_queue_unit_tb.sv
